/* sv/kei_pkg.sv */
// Shared types and constants for the keyframe ease interpolator.
// No dependencies; every other file of the block refers to this package.
package kei_pkg;

    localparam int TIME_W  = 48;
    localparam int VALUE_W = 32;
    localparam int T_FRAC  = 16;

    // Easing mode codes.
    localparam logic EASE_LINEAR   = 1'b0;
    localparam logic EASE_QUAD_OUT = 1'b1;

    // Fields that ride alongside the division unchanged.
    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] from_value;
        logic signed [VALUE_W-1:0] to_value;
        logic                      in_progress;
    } t_side;

endpackage

/* sv/keyframe_ease_interpolator_top.sv */
// Top level of the keyframe ease interpolator: front stage, divider, blend.
// Depends on kei_pkg, kei_front, kei_divider and kei_blend.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+------------------------------------------------
//  input   | i_valid / o_ready   | i_func, i_from_value, i_to_value, i_*_time
//  output  | o_valid / i_ready   | o_value, o_in_progress
//
// One item is taken every cycle while no finished result waits with i_ready low; each
// result passes one entry stage, sixteen division steps, ease, multiply, output register.
// The sixteen one-bit restoring division steps make up most of the pipeline depth.
// Reset clears only the valid bits of every stage.
// The whole pipeline holds while a result waits and i_ready is low; o_ready is
// then low as well, so nothing is lost or repeated.
module keyframe_ease_interpolator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic signed [kei_pkg::VALUE_W-1:0]  i_from_value,
    input  logic signed [kei_pkg::VALUE_W-1:0]  i_to_value,
    input  logic [kei_pkg::TIME_W-1:0]          i_begin_time,
    input  logic [kei_pkg::TIME_W-1:0]          i_end_time,
    input  logic [kei_pkg::TIME_W-1:0]          i_now_time,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [kei_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_in_progress
);

    logic                       w_adv;
    logic                       w_f_valid;
    logic [kei_pkg::TIME_W-1:0] w_num;
    logic [kei_pkg::TIME_W-1:0] w_den;
    kei_pkg::t_side             w_f_side;
    logic                       w_d_valid;
    logic [kei_pkg::T_FRAC-1:0] w_quo;
    kei_pkg::t_side             w_d_side;

    // Every stage moves together unless a finished result is still waiting.
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    kei_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_from_value (i_from_value),
        .i_to_value   (i_to_value),
        .i_begin_time (i_begin_time),
        .i_end_time   (i_end_time),
        .i_now_time   (i_now_time),
        .o_valid      (w_f_valid),
        .o_num        (w_num),
        .o_den        (w_den),
        .o_side       (w_f_side)
    );

    kei_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_f_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_quo   (w_quo),
        .o_side  (w_d_side)
    );

    kei_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (w_d_valid),
        .i_quo         (w_quo),
        .i_side        (w_d_side),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_in_progress (o_in_progress)
    );

endmodule

/* sv/kei_front.sv */
// Entry stage: decides in-progress and forms the numerator and denominator.
// Depends on kei_pkg.
module kei_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic                         i_func,
    input  logic signed [kei_pkg::VALUE_W-1:0] i_from_value,
    input  logic signed [kei_pkg::VALUE_W-1:0] i_to_value,
    input  logic [kei_pkg::TIME_W-1:0]   i_begin_time,
    input  logic [kei_pkg::TIME_W-1:0]   i_end_time,
    input  logic [kei_pkg::TIME_W-1:0]   i_now_time,
    output logic                         o_valid,
    output logic [kei_pkg::TIME_W-1:0]   o_num,
    output logic [kei_pkg::TIME_W-1:0]   o_den,
    output kei_pkg::t_side               o_side
);

    logic                       r_valid;
    logic [kei_pkg::TIME_W-1:0] r_num;
    logic [kei_pkg::TIME_W-1:0] r_den;
    kei_pkg::t_side             r_side;

    logic                       n_prog;
    logic                       n_zero;
    logic [kei_pkg::TIME_W-1:0] n_num;
    logic [kei_pkg::TIME_W-1:0] n_den;
    kei_pkg::t_side             n_side;

    always_comb begin
        n_prog = (i_now_time < i_end_time);
        n_zero = (i_now_time <= i_begin_time);
        // A clamped fraction divides zero by one, so a clamped item never gives the divider a zero divisor.
        if (n_zero) begin
            n_num = '0;
            n_den = kei_pkg::TIME_W'(1);
        end else begin
            n_num = i_now_time - i_begin_time;
            n_den = i_end_time - i_begin_time;
        end
        n_side.func        = i_func;
        n_side.from_value  = i_from_value;
        n_side.to_value    = i_to_value;
        n_side.in_progress = n_prog;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

/* sv/kei_div_stage.sv */
// One registered step of restoring division: yields one quotient bit.
// Depends on kei_pkg.
module kei_div_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [kei_pkg::TIME_W-1:0]   i_rem,
    input  logic [kei_pkg::TIME_W-1:0]   i_den,
    input  logic [kei_pkg::T_FRAC-1:0]   i_quo,
    input  kei_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [kei_pkg::TIME_W-1:0]   o_rem,
    output logic [kei_pkg::TIME_W-1:0]   o_den,
    output logic [kei_pkg::T_FRAC-1:0]   o_quo,
    output kei_pkg::t_side               o_side
);

    logic                       r_valid;
    logic [kei_pkg::TIME_W-1:0] r_rem;
    logic [kei_pkg::TIME_W-1:0] r_den;
    logic [kei_pkg::T_FRAC-1:0] r_quo;
    kei_pkg::t_side             r_side;

    logic [kei_pkg::TIME_W:0]   n_shift;
    logic [kei_pkg::TIME_W:0]   n_diff;
    logic                       n_bit;
    logic [kei_pkg::TIME_W-1:0] n_rem;

    always_comb begin
        n_shift = {i_rem, 1'b0};
        n_diff  = n_shift - {1'b0, i_den};
        n_bit   = (n_shift >= {1'b0, i_den});
        // When the numerator is below the divisor, the remainder stays below it and so fits the time width.
        n_rem   = n_bit ? n_diff[kei_pkg::TIME_W-1:0] : n_shift[kei_pkg::TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= {i_quo[kei_pkg::T_FRAC-2:0], n_bit};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

/* sv/kei_divider.sv */
// Pipelined fraction divider: one kei_div_stage per quotient bit.
// Depends on kei_pkg and kei_div_stage.
module kei_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [kei_pkg::TIME_W-1:0]   i_num,
    input  logic [kei_pkg::TIME_W-1:0]   i_den,
    input  kei_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [kei_pkg::T_FRAC-1:0]   o_quo,
    output kei_pkg::t_side               o_side
);

    localparam int N = kei_pkg::T_FRAC;

    logic                       w_valid [N+1];
    logic [kei_pkg::TIME_W-1:0] w_rem   [N+1];
    logic [kei_pkg::TIME_W-1:0] w_den   [N+1];
    logic [kei_pkg::T_FRAC-1:0] w_quo   [N+1];
    kei_pkg::t_side             w_side  [N+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_quo[0]   = '0;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < N; g++) begin : g_step
        kei_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[N];
    assign o_quo   = w_quo[N];
    assign o_side  = w_side[N];

endmodule

/* sv/kei_blend.sv */
// Easing, product with the value span, rounding and final selection.
// Three register stages; depends on kei_pkg.
module kei_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [kei_pkg::T_FRAC-1:0]   i_quo,
    input  kei_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic signed [kei_pkg::VALUE_W-1:0] o_value,
    output logic                         o_in_progress
);

    localparam int EW = kei_pkg::T_FRAC;
    localparam int DW = kei_pkg::VALUE_W + 1;
    localparam int PW = EW + 1 + DW;
    localparam int QW = 2 * EW + 2;

    // Stage A: eased fraction and span.
    logic                             r_va;
    logic [EW-1:0]                    r_e;
    logic signed [DW-1:0]             r_diff;
    logic signed [kei_pkg::VALUE_W-1:0] r_from_a;
    logic signed [kei_pkg::VALUE_W-1:0] r_to_a;
    logic                             r_prog_a;

    // Stage B: product.
    logic                             r_vb;
    logic signed [PW-1:0]             r_prod;
    logic signed [kei_pkg::VALUE_W-1:0] r_from_b;
    logic signed [kei_pkg::VALUE_W-1:0] r_to_b;
    logic                             r_prog_b;

    // Stage C: output register.
    logic                             r_vc;
    logic signed [kei_pkg::VALUE_W-1:0] r_value;
    logic                             r_prog_c;

    logic [QW-1:0]                    n_sq;
    logic [EW-1:0]                    n_e;
    logic signed [DW-1:0]             n_diff;
    logic signed [PW-1:0]             n_prod;
    logic signed [PW-1:0]             n_round;
    logic signed [PW-1:0]             n_sum;
    logic signed [kei_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        // Ease-out t(2-t) in Q0.16: t * (2^17 - t), then drop the fraction bits.
        n_sq = QW'(i_quo) * (QW'(1) << (EW + 1)) - QW'(i_quo) * QW'(i_quo);
        if (i_side.func == kei_pkg::EASE_QUAD_OUT) begin
            n_e = n_sq[2*EW-1:EW];
        end else begin
            n_e = i_quo;
        end
        n_diff = DW'(i_side.to_value) - DW'(i_side.from_value);
    end

    always_comb begin
        n_prod = PW'($signed({1'b0, r_e})) * PW'(r_diff);
    end

    always_comb begin
        // Arithmetic shift after adding a half rounds to nearest, ties towards plus infinity.
        n_round = (r_prod + (PW'(1) <<< (EW - 1))) >>> EW;
        n_sum   = n_round + PW'(r_from_b);
        n_value = r_prog_b ? n_sum[kei_pkg::VALUE_W-1:0] : r_to_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e      <= n_e;
            r_diff   <= n_diff;
            r_from_a <= i_side.from_value;
            r_to_a   <= i_side.to_value;
            r_prog_a <= i_side.in_progress;
            r_prod   <= n_prod;
            r_from_b <= r_from_a;
            r_to_b   <= r_to_a;
            r_prog_b <= r_prog_a;
            r_value  <= n_value;
            r_prog_c <= r_prog_b;
        end
    end

    assign o_valid       = r_vc;
    assign o_value       = r_value;
    assign o_in_progress = r_prog_c;

endmodule

/* bench/kei_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the keyframe ease interpolator: predicts each tween result and compares.
// Depends on kei_pkg for widths and easing mode codes.
module kei_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_func,
    input  logic signed [kei_pkg::VALUE_W-1:0]  i_from_value,
    input  logic signed [kei_pkg::VALUE_W-1:0]  i_to_value,
    input  logic [kei_pkg::TIME_W-1:0]          i_begin_time,
    input  logic [kei_pkg::TIME_W-1:0]          i_end_time,
    input  logic [kei_pkg::TIME_W-1:0]          i_now_time,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [kei_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_in_progress,
    output int                                  o_errors,
    output int                                  o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [kei_pkg::VALUE_W-1:0] value;
        logic                               in_progress;
    } t_tween;

    t_tween tween_q[$];
    t_tween oldest;
    int     n_err = 0;

    // Blend the two values by the eased fraction of the elapsed transition.
    function automatic t_tween tween_eval(
        input logic                               func,
        input logic signed [kei_pkg::VALUE_W-1:0] from,
        input logic signed [kei_pkg::VALUE_W-1:0] to,
        input logic [kei_pkg::TIME_W-1:0]         t_start,
        input logic [kei_pkg::TIME_W-1:0]         t_stop,
        input logic [kei_pkg::TIME_W-1:0]         t_now
    );
        logic [63:0] elapsed;
        logic [63:0] span;
        logic [63:0] frac;
        logic [63:0] eased;
        longint      delta;
        longint      product;
        longint      blended;
        t_tween      r;
        if (t_now < t_stop) begin
            // A clock at or before the start holds the property at its start value.
            if (t_now <= t_start) begin
                frac = 64'd0;
            end else begin
                elapsed = 64'(t_now - t_start);
                span    = 64'(t_stop - t_start);
                frac    = (elapsed << kei_pkg::T_FRAC) / span;
            end
            if (func == kei_pkg::EASE_QUAD_OUT) begin
                eased = (frac * ((64'd2 << kei_pkg::T_FRAC) - frac)) >> kei_pkg::T_FRAC;
            end else begin
                eased = frac;
            end
            delta   = longint'(to) - longint'(from);
            product = longint'(eased) * delta;
            // Arithmetic shift of a signed value rounds towards minus infinity.
            blended = longint'(from)
                    + ((product + (longint'(1) << (kei_pkg::T_FRAC - 1))) >>> kei_pkg::T_FRAC);
            r.value       = blended[kei_pkg::VALUE_W-1:0];
            r.in_progress = 1'b1;
        end else begin
            r.value       = to;
            r.in_progress = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                tween_q.push_back(tween_eval(i_func, i_from_value, i_to_value,
                                             i_begin_time, i_end_time, i_now_time));
            end
            if (i_out_valid && i_out_ready) begin
                if (tween_q.size() == 0) begin
                    n_err++;
                    if (n_err <= REPORT_LIMIT) begin
                        $display("unexpected result: value %0d in_progress %0b",
                                 i_value, i_in_progress);
                    end
                end else begin
                    oldest = tween_q.pop_front();
                    if (i_value !== oldest.value || i_in_progress !== oldest.in_progress) begin
                        n_err++;
                        if (n_err <= REPORT_LIMIT) begin
                            $display({"mismatch: expected value %0d in_progress %0b, ",
                                      "got value %0d in_progress %0b"},
                                     oldest.value, oldest.in_progress,
                                     i_value, i_in_progress);
                        end
                    end
                end
            end
        end
        o_errors  <= n_err;
        o_pending <= tween_q.size();
    end

endmodule

/* bench/tb_keyframe_ease_interpolator_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for keyframe_ease_interpolator_top: directed and random tween items.
// Depends on kei_pkg, the block under test and kei_checker.
module tb_keyframe_ease_interpolator_top;

    localparam int                     RANDOM_ITEMS   = 1000;
    localparam int                     HOLD_CYCLES    = 200;
    localparam int                     WATCHDOG_LIMIT = 3000;
    localparam int                     DRAIN_CYCLES   = 40;
    localparam logic [kei_pkg::TIME_W-1:0] T_MAX = {kei_pkg::TIME_W{1'b1}};
    localparam logic signed [kei_pkg::VALUE_W-1:0] V_MIN =
        {1'b1, {(kei_pkg::VALUE_W-1){1'b0}}};
    localparam logic signed [kei_pkg::VALUE_W-1:0] V_MAX =
        {1'b0, {(kei_pkg::VALUE_W-1){1'b1}}};

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic                               i_func;
    logic signed [kei_pkg::VALUE_W-1:0] i_from_value;
    logic signed [kei_pkg::VALUE_W-1:0] i_to_value;
    logic [kei_pkg::TIME_W-1:0]         i_begin_time;
    logic [kei_pkg::TIME_W-1:0]         i_end_time;
    logic [kei_pkg::TIME_W-1:0]         i_now_time;
    logic                               o_valid;
    logic                               i_ready;
    logic signed [kei_pkg::VALUE_W-1:0] o_value;
    logic                               o_in_progress;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic steady      = 1'b0;
    logic hold_req    = 1'b0;

    keyframe_ease_interpolator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_from_value  (i_from_value),
        .i_to_value    (i_to_value),
        .i_begin_time  (i_begin_time),
        .i_end_time    (i_end_time),
        .i_now_time    (i_now_time),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_in_progress (o_in_progress)
    );

    kei_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_func        (i_func),
        .i_from_value  (i_from_value),
        .i_to_value    (i_to_value),
        .i_begin_time  (i_begin_time),
        .i_end_time    (i_end_time),
        .i_now_time    (i_now_time),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_value       (o_value),
        .i_in_progress (o_in_progress),
        .o_errors      (fail_count),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_keyframe_ease_interpolator_top: FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off that fills the pipeline.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!steady && $urandom_range(0, 99) < 9) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [kei_pkg::TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[kei_pkg::TIME_W-1:0];
    endfunction

    function automatic logic signed [kei_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(
        input logic                               func,
        input logic signed [kei_pkg::VALUE_W-1:0] from,
        input logic signed [kei_pkg::VALUE_W-1:0] to,
        input logic [kei_pkg::TIME_W-1:0]         t_start,
        input logic [kei_pkg::TIME_W-1:0]         t_stop,
        input logic [kei_pkg::TIME_W-1:0]         t_now
    );
        if (!steady && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_from_value <= from;
        i_to_value   <= to;
        i_begin_time <= t_start;
        i_end_time   <= t_stop;
        i_now_time   <= t_now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_item();
        logic [kei_pkg::TIME_W-1:0] a, b, c, lo, mid, hi, t_start, t_stop, t_now;
        logic [kei_pkg::TIME_W-1:0] span;
        logic signed [kei_pkg::VALUE_W-1:0] from, to;
        int kind;
        a = rand_time();
        b = rand_time();
        c = rand_time();
        lo  = (a < b) ? ((a < c) ? a : c) : ((b < c) ? b : c);
        hi  = (a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c);
        mid = a ^ b ^ c ^ lo ^ hi;
        from = rand_value();
        to   = ($urandom_range(0, 9) == 0)
             ? from + kei_pkg::VALUE_W'($urandom_range(0, 3)) - 1
             : rand_value();
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            t_start = lo; t_now = mid; t_stop = hi;
        end else if (kind < 65) begin
            // Short transitions give fractions with few significant steps.
            span    = kei_pkg::TIME_W'($urandom_range(1, 4096));
            t_start = (a > T_MAX - span) ? T_MAX - span : a;
            t_stop  = t_start + span;
            t_now   = t_start + kei_pkg::TIME_W'($urandom_range(0, int'(span) - 1));
        end else if (kind < 77) begin
            t_start = a; t_stop = lo; t_now = ($urandom_range(0, 1) != 0) ? hi : lo;
        end else if (kind < 87) begin
            t_now = lo; t_start = mid; t_stop = hi;
        end else if (kind < 93) begin
            t_now = lo; t_stop = mid; t_start = hi;
        end else begin
            t_start = a; t_stop = b; t_now = c;
        end
        send_item(1'($urandom_range(0, 1)), from, to, t_start, t_stop, t_now);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = kei_pkg::EASE_LINEAR;
        i_from_value = '0;
        i_to_value   = '0;
        i_begin_time = '0;
        i_end_time   = '0;
        i_now_time   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: midpoint, full range and the boundary cases of time.
        send_item(kei_pkg::EASE_LINEAR,   32'sd0, 32'sd6553600, 48'd1000, 48'd2000, 48'd1500);
        send_item(kei_pkg::EASE_QUAD_OUT, 32'sd0, 32'sd6553600, 48'd1000, 48'd2000, 48'd1500);
        send_item(kei_pkg::EASE_LINEAR,   V_MIN, V_MAX, '0, T_MAX, T_MAX - 1);
        send_item(kei_pkg::EASE_QUAD_OUT, V_MIN, V_MAX, '0, T_MAX, T_MAX - 1);
        send_item(kei_pkg::EASE_LINEAR,   V_MAX, V_MIN, '0, T_MAX, T_MAX - 1);
        send_item(kei_pkg::EASE_QUAD_OUT, V_MAX, V_MIN, '0, T_MAX, T_MAX >> 1);
        send_item(kei_pkg::EASE_LINEAR,   V_MIN, V_MAX, '0, T_MAX, 48'd1);
        send_item(kei_pkg::EASE_LINEAR,   32'sd5, -32'sd7, 48'd10, 48'd20, 48'd20);
        send_item(kei_pkg::EASE_QUAD_OUT, 32'sd5, -32'sd7, 48'd10, 48'd20, T_MAX);
        send_item(kei_pkg::EASE_LINEAR,   32'sd123, 32'sd456, 48'd500, 48'd900, 48'd100);
        send_item(kei_pkg::EASE_QUAD_OUT, 32'sd123, 32'sd456, 48'd500, 48'd900, 48'd500);
        send_item(kei_pkg::EASE_LINEAR,   -32'sd99, 32'sd99, 48'd900, 48'd500, 48'd100);
        send_item(kei_pkg::EASE_QUAD_OUT, -32'sd99, 32'sd99, 48'd500, 48'd500, 48'd499);
        send_item(kei_pkg::EASE_LINEAR,   -32'sd99, 32'sd99, 48'd500, 48'd500, 48'd500);
        send_item(kei_pkg::EASE_QUAD_OUT, V_MAX, V_MIN, '0, '0, '0);
        send_item(kei_pkg::EASE_LINEAR,   V_MIN, V_MAX, T_MAX, T_MAX, T_MAX);
        send_item(kei_pkg::EASE_QUAD_OUT, 32'sd777, 32'sd777, 48'd0, 48'd64, 48'd33);
        send_item(kei_pkg::EASE_LINEAR,   32'sd0, -32'sd1, 48'd0, 48'd2, 48'd1);
        send_item(kei_pkg::EASE_LINEAR,   -32'sd1, 32'sd0, 48'd0, 48'd2, 48'd1);
        send_item(kei_pkg::EASE_QUAD_OUT, 32'sd1, -32'sd2, 48'd0, 48'd3, 48'd2);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) hold_req <= 1'b1;
            if (n == 300) steady <= 1'b1;
            if (n == 600) steady <= 1'b0;
            if (n == 700) wait_for_results();
            send_random_item();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_keyframe_ease_interpolator_top: PASS");
        end else begin
            $display("tb_keyframe_ease_interpolator_top: FAIL");
        end
        $finish;
    end

endmodule
